// File: design/tfct_pkg.sv
// shared types and constants of the thermal throttle governor
`timescale 1ns / 1ps
`default_nettype none

package tfct_pkg;

	localparam int TEMP_W      = 8;
	localparam int NUM_SENSORS = 4;
	// widest index and core count the block supports
	localparam int IDX_MAX_W   = 8;
	localparam int CORES_MAX   = 32;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 32;

	localparam logic [TEMP_W-1:0]    RST_FREQ_LIMIT_TEMP = 8'd65;
	localparam logic [TEMP_W-1:0]    RST_FREQ_HYSTERESIS = 8'd5;
	localparam logic [IDX_MAX_W-1:0] RST_INDEX_STEP      = 8'd2;
	localparam logic [IDX_MAX_W-1:0] RST_LOW_INDEX       = 8'd4;
	localparam logic [IDX_MAX_W-1:0] RST_HIGH_INDEX      = 8'd15;
	localparam logic [TEMP_W-1:0]    RST_CORE_LIMIT_TEMP = 8'd75;
	localparam logic [TEMP_W-1:0]    RST_CORE_HYSTERESIS = 8'd10;
	localparam logic [CORES_MAX-1:0] RST_CORE_MASK       = 32'h0000_000e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FREQ_LIMIT_TEMP = 4'd0,
		REG_FREQ_HYSTERESIS = 4'd1,
		REG_INDEX_STEP      = 4'd2,
		REG_LOW_INDEX       = 4'd3,
		REG_HIGH_INDEX      = 4'd4,
		REG_CORE_LIMIT_TEMP = 4'd5,
		REG_CORE_HYSTERESIS = 4'd6,
		REG_CORE_MASK       = 4'd7
	} tfct_reg_t;

	typedef logic [NUM_SENSORS-1:0][TEMP_W-1:0] tfct_temps_t;

	// configuration, zero-extended to the widest supported sizes
	typedef struct packed {
		logic [TEMP_W-1:0]    freq_limit_temp;
		logic [TEMP_W-1:0]    freq_hysteresis;
		logic [IDX_MAX_W-1:0] index_step;
		logic [IDX_MAX_W-1:0] low_index;
		logic [IDX_MAX_W-1:0] high_index;
		logic [TEMP_W-1:0]    core_limit_temp;
		logic [TEMP_W-1:0]    core_hysteresis;
		logic [CORES_MAX-1:0] core_mask;
	} tfct_cfg_t;

	typedef struct packed {
		logic unlimited;
		logic hotplug;
	} tfct_gov_flags_t;

	typedef struct packed {
		logic offline;
		logic online;
	} tfct_core_req_t;

endpackage

`default_nettype wire

// File: design/tfct_if.sv
// channel interfaces: configuration write, poll tick and result
`timescale 1ns / 1ps
`default_nettype none

interface tfct_cfg_if import tfct_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface tfct_tick_if import tfct_pkg::*; #(
	parameter int NUM_CORES = 4
) ();
	logic                 valid;
	logic                 ready;
	logic [TEMP_W-1:0]    temp_a;
	logic [TEMP_W-1:0]    temp_b;
	logic [TEMP_W-1:0]    temp_c;
	logic [TEMP_W-1:0]    temp_d;
	logic [NUM_CORES-1:0] online_cores;

	modport source (output valid, output temp_a, output temp_b, output temp_c,
		output temp_d, output online_cores, input ready);
	modport sink (input valid, input temp_a, input temp_b, input temp_c,
		input temp_d, input online_cores, output ready);
endinterface

interface tfct_res_if #(
	parameter int NUM_CORES  = 4,
	parameter int INDEX_BITS = 6
) ();
	localparam int CORE_W = $clog2(NUM_CORES);

	logic                  valid;
	logic                  ready;
	logic                  limit_update;
	logic [INDEX_BITS-1:0] limit_index;
	logic                  unlimited;
	logic                  offline_request;
	logic                  online_request;
	logic [CORE_W-1:0]     core_number;
	logic [NUM_CORES-1:0]  offlined_cores;

	modport source (output valid, output limit_update, output limit_index,
		output unlimited, output offline_request, output online_request,
		output core_number, output offlined_cores, input ready);
	modport sink (input valid, input limit_update, input limit_index,
		input unlimited, input offline_request, input online_request,
		input core_number, input offlined_cores, output ready);
endinterface

`default_nettype wire

// File: design/tfct_cfg_regs.sv
// configuration register file of the thermal throttle governor
`timescale 1ns / 1ps
`default_nettype none

module tfct_cfg_regs import tfct_pkg::*; #(
	parameter int NUM_CORES  = 4,
	parameter int INDEX_BITS = 6
) (
	input  wire       clk,
	input  wire       arst_n,
	tfct_cfg_if.sink  cfg,
	output tfct_cfg_t cfg_o
);

	logic [TEMP_W-1:0]     freq_limit_temp_q;
	logic [TEMP_W-1:0]     freq_hysteresis_q;
	logic [INDEX_BITS-1:0] index_step_q;
	logic [INDEX_BITS-1:0] low_index_q;
	logic [INDEX_BITS-1:0] high_index_q;
	logic [TEMP_W-1:0]     core_limit_temp_q;
	logic [TEMP_W-1:0]     core_hysteresis_q;
	logic [NUM_CORES-1:0]  core_mask_q;

	// writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_limit_temp_q <= RST_FREQ_LIMIT_TEMP;
			freq_hysteresis_q <= RST_FREQ_HYSTERESIS;
			index_step_q      <= RST_INDEX_STEP[INDEX_BITS-1:0];
			low_index_q       <= RST_LOW_INDEX[INDEX_BITS-1:0];
			high_index_q      <= RST_HIGH_INDEX[INDEX_BITS-1:0];
			core_limit_temp_q <= RST_CORE_LIMIT_TEMP;
			core_hysteresis_q <= RST_CORE_HYSTERESIS;
			core_mask_q       <= RST_CORE_MASK[NUM_CORES-1:0];
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FREQ_LIMIT_TEMP: freq_limit_temp_q <= cfg.data[TEMP_W-1:0];
				REG_FREQ_HYSTERESIS: freq_hysteresis_q <= cfg.data[TEMP_W-1:0];
				REG_INDEX_STEP:      index_step_q      <= cfg.data[INDEX_BITS-1:0];
				REG_LOW_INDEX:       low_index_q       <= cfg.data[INDEX_BITS-1:0];
				REG_HIGH_INDEX:      high_index_q      <= cfg.data[INDEX_BITS-1:0];
				REG_CORE_LIMIT_TEMP: core_limit_temp_q <= cfg.data[TEMP_W-1:0];
				REG_CORE_HYSTERESIS: core_hysteresis_q <= cfg.data[TEMP_W-1:0];
				REG_CORE_MASK:       core_mask_q       <= cfg.data[NUM_CORES-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg_o.freq_limit_temp = freq_limit_temp_q;
		cfg_o.freq_hysteresis = freq_hysteresis_q;
		cfg_o.index_step      = IDX_MAX_W'(index_step_q);
		cfg_o.low_index       = IDX_MAX_W'(low_index_q);
		cfg_o.high_index      = IDX_MAX_W'(high_index_q);
		cfg_o.core_limit_temp = core_limit_temp_q;
		cfg_o.core_hysteresis = core_hysteresis_q;
		cfg_o.core_mask       = CORES_MAX'(core_mask_q);
	end

endmodule

`default_nettype wire

// File: design/tfct_freq_gov.sv
// frequency limit index governor with hysteresis
`timescale 1ns / 1ps
`default_nettype none

module tfct_freq_gov import tfct_pkg::*; #(
	parameter int INDEX_BITS = 6
) (
	input  tfct_cfg_t             cfg_i,
	input  tfct_temps_t           temps,
	input  logic                  reads_ok,
	input  logic [INDEX_BITS-1:0] cur_index,
	input  logic [INDEX_BITS-1:0] applied_index,
	input  tfct_gov_flags_t       flags_i,
	output logic [INDEX_BITS-1:0] cur_index_nxt,
	output logic [INDEX_BITS-1:0] applied_index_nxt,
	output tfct_gov_flags_t       flags_nxt,
	output logic                  update
);

	logic [INDEX_BITS-1:0] step;
	logic [INDEX_BITS-1:0] low_idx;
	logic [INDEX_BITS-1:0] high_idx;
	logic [TEMP_W-1:0]     cool_thr;
	logic                  hot;
	logic                  cool;
	logic [INDEX_BITS:0]   down_bound;
	logic [INDEX_BITS:0]   up_sum;
	logic [INDEX_BITS-1:0] nidx;
	logic                  nunl;
	logic                  hp;
	logic                  decided;

	always_comb begin
		step     = cfg_i.index_step[INDEX_BITS-1:0];
		low_idx  = cfg_i.low_index[INDEX_BITS-1:0];
		high_idx = cfg_i.high_index[INDEX_BITS-1:0];
		cool_thr = (cfg_i.freq_limit_temp > cfg_i.freq_hysteresis) ?
			cfg_i.freq_limit_temp - cfg_i.freq_hysteresis : '0;

		hot  = 1'b0;
		cool = 1'b1;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (temps[i] >= cfg_i.freq_limit_temp) hot = 1'b1;
			if (temps[i] >= cool_thr) cool = 1'b0;
		end

		// cur - step < low  <=>  cur < step + low
		down_bound = {1'b0, step} + {1'b0, low_idx};
		up_sum     = {1'b0, cur_index} + {1'b0, step};

		cur_index_nxt = cur_index;
		nidx          = applied_index;
		nunl          = flags_i.unlimited;
		hp            = flags_i.hotplug;
		decided       = 1'b0;

		if (hot) begin
			hp = 1'b1;
			if (cur_index == low_idx) begin
				decided = 1'b1;
			end else begin
				cur_index_nxt = ({1'b0, cur_index} < down_bound) ? low_idx : cur_index - step;
				nidx          = cur_index_nxt;
				nunl          = 1'b0;
			end
		end else if (cool) begin
			if (cur_index == high_idx) begin
				hp      = 1'b0;
				decided = 1'b1;
			end else if (up_sum >= {1'b0, high_idx}) begin
				cur_index_nxt = high_idx;
				nidx          = high_idx;
				nunl          = 1'b1;
				hp            = 1'b0;
			end else begin
				cur_index_nxt = up_sum[INDEX_BITS-1:0];
				nidx          = cur_index_nxt;
				nunl          = 1'b0;
				hp            = 1'b1;
			end
		end

		applied_index_nxt   = applied_index;
		flags_nxt.unlimited = flags_i.unlimited;
		update              = 1'b0;
		if (!decided) begin
			if (nidx == applied_index && nunl == flags_i.unlimited) begin
				hp = 1'b0;
			end else begin
				applied_index_nxt   = nidx;
				flags_nxt.unlimited = nunl;
				update              = 1'b1;
			end
		end
		flags_nxt.hotplug = hp;

		// failed sensor read: hold everything
		if (!reads_ok) begin
			cur_index_nxt     = cur_index;
			applied_index_nxt = applied_index;
			flags_nxt         = flags_i;
			update            = 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: design/tfct_core_ctl.sv
// core offline / online control with hysteresis
`timescale 1ns / 1ps
`default_nettype none

module tfct_core_ctl import tfct_pkg::*; #(
	parameter int NUM_CORES = 4,
	localparam int CORE_W   = $clog2(NUM_CORES)
) (
	input  tfct_cfg_t            cfg_i,
	input  tfct_temps_t          temps,
	input  logic                 reads_ok,
	input  logic                 hotplug_after,
	input  logic [NUM_CORES-1:0] online,
	input  logic [NUM_CORES-1:0] offlined,
	output logic [NUM_CORES-1:0] offlined_nxt,
	output tfct_core_req_t       req,
	output logic [CORE_W-1:0]    core_number
);

	logic [NUM_CORES-1:0] mask;
	logic [TEMP_W-1:0]    cool_thr;
	logic                 chot;
	logic                 ccool;
	logic                 run;
	logic                 found;
	logic                 done;
	logic [CORE_W-1:0]    pick;

	always_comb begin
		mask     = cfg_i.core_mask[NUM_CORES-1:0];
		cool_thr = (cfg_i.core_limit_temp > cfg_i.core_hysteresis) ?
			cfg_i.core_limit_temp - cfg_i.core_hysteresis : '0;

		chot  = 1'b0;
		ccool = 1'b1;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (temps[i] >= cfg_i.core_limit_temp) chot = 1'b1;
			if (temps[i] > cool_thr) ccool = 1'b0;
		end

		run = reads_ok && (mask != '0) &&
			((cfg_i.freq_limit_temp >= cfg_i.core_limit_temp) || hotplug_after);

		// highest masked core above zero that is not already marked and offline
		found = 1'b0;
		pick  = '0;
		for (int c = 1; c < NUM_CORES; c++) begin
			if (mask[c] && !(offlined[c] && !online[c])) begin
				found = 1'b1;
				pick  = CORE_W'(c);
			end
		end

		offlined_nxt = offlined;
		req          = '0;
		core_number  = '0;
		done         = 1'b0;
		if (run) begin
			if (chot) begin
				if (found) begin
					req.offline        = 1'b1;
					core_number        = pick;
					offlined_nxt[pick] = 1'b1;
				end
			end else if (offlined != '0 && ccool) begin
				// unmark upward up to and including the first marked core that is offline
				for (int c = 0; c < NUM_CORES; c++) begin
					if (!done && offlined[c]) begin
						offlined_nxt[c] = 1'b0;
						if (!online[c]) begin
							req.online  = 1'b1;
							core_number = CORE_W'(c);
							done        = 1'b1;
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: design/thermal_freq_and_core_throttle.sv
// top level of the thermal frequency limit and core throttle governor
`timescale 1ns / 1ps
`default_nettype none

// Thermal throttle governor. Each poll tick transaction (four sensor
// temperatures and the online-core mask) produces exactly one result
// transaction: the applied frequency-limit index, an update flag, the
// unlimited flag, at most one core offline/online request and the set of
// cores thermal control has marked offline. A tick with any zero reading
// changes nothing. The block takes one tick per clock cycle while the
// result sink keeps taking results; a result passes the input register,
// then one combinational pass through the frequency governor and core
// control, into the result register. The governor state is read and
// written in that same pass, so back-to-back ticks see each other's effect
// in order. The next tick waits in the input register while the result
// register is held, so a stalled sink holds at most two ticks.
// Configuration writes are always taken and should be made only while no
// tick is in flight; there is no clearing pass after reset.
module thermal_freq_and_core_throttle import tfct_pkg::*; #(
	parameter int NUM_CORES  = 4,
	parameter int INDEX_BITS = 6
) (
	input  wire       clk,
	input  wire       arst_n,
	tfct_cfg_if.sink  cfg,
	tfct_tick_if.sink tick,
	tfct_res_if.source res
);

	localparam int CORE_W = $clog2(NUM_CORES);

	tfct_cfg_t cfg_w;

	// input stage
	logic                  tick_valid_s1;
	tfct_temps_t           temps_s1;
	logic [NUM_CORES-1:0]  online_s1;

	// result stage
	logic                  res_valid_s2;
	logic                  limit_update_s2;
	logic [INDEX_BITS-1:0] limit_index_s2;
	logic                  unlimited_s2;
	logic                  offline_request_s2;
	logic                  online_request_s2;
	logic [CORE_W-1:0]     core_number_s2;
	logic [NUM_CORES-1:0]  offlined_cores_s2;

	// governor state
	logic [INDEX_BITS-1:0] cur_index_q;
	logic [INDEX_BITS-1:0] applied_index_q;
	tfct_gov_flags_t       flags_q;
	logic [NUM_CORES-1:0]  offlined_q;

	// next state from the single pass
	logic                  reads_ok;
	logic                  advance;
	logic [INDEX_BITS-1:0] cur_index_nxt;
	logic [INDEX_BITS-1:0] applied_index_nxt;
	tfct_gov_flags_t       flags_nxt;
	logic                  update_nxt;
	logic [NUM_CORES-1:0]  offlined_nxt;
	tfct_core_req_t        req_nxt;
	logic [CORE_W-1:0]     core_number_nxt;

	tfct_cfg_regs #(
		.NUM_CORES (NUM_CORES),
		.INDEX_BITS(INDEX_BITS)
	) u_cfg_regs (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.cfg_o (cfg_w)
	);

	// a failed read shows up as a zero on any sensor
	always_comb begin
		reads_ok = 1'b1;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (temps_s1[i] == '0) reads_ok = 1'b0;
		end
	end

	// the s1 item moves on when the result register is free or being drained
	assign advance    = tick_valid_s1 && (!res_valid_s2 || res.ready);
	assign tick.ready = !tick_valid_s1 || advance;

	tfct_freq_gov #(
		.INDEX_BITS(INDEX_BITS)
	) u_freq_gov (
		.cfg_i            (cfg_w),
		.temps            (temps_s1),
		.reads_ok         (reads_ok),
		.cur_index        (cur_index_q),
		.applied_index    (applied_index_q),
		.flags_i          (flags_q),
		.cur_index_nxt    (cur_index_nxt),
		.applied_index_nxt(applied_index_nxt),
		.flags_nxt        (flags_nxt),
		.update           (update_nxt)
	);

	// core control gates on the hotplug flag as left by the frequency step
	tfct_core_ctl #(
		.NUM_CORES(NUM_CORES)
	) u_core_ctl (
		.cfg_i        (cfg_w),
		.temps        (temps_s1),
		.reads_ok     (reads_ok),
		.hotplug_after(flags_nxt.hotplug),
		.online       (online_s1),
		.offlined     (offlined_q),
		.offlined_nxt (offlined_nxt),
		.req          (req_nxt),
		.core_number  (core_number_nxt)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			tick_valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			temps_s1  <= {tick.temp_d, tick.temp_c, tick.temp_b, tick.temp_a};
			online_s1 <= tick.online_cores;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (res.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			limit_update_s2    <= update_nxt;
			limit_index_s2     <= applied_index_nxt;
			unlimited_s2       <= flags_nxt.unlimited;
			offline_request_s2 <= req_nxt.offline;
			online_request_s2  <= req_nxt.online;
			core_number_s2     <= core_number_nxt;
			offlined_cores_s2  <= offlined_nxt;
		end
	end

	// governor state, committed as the item leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_index_q       <= RST_HIGH_INDEX[INDEX_BITS-1:0];
			applied_index_q   <= RST_HIGH_INDEX[INDEX_BITS-1:0];
			flags_q.unlimited <= 1'b1;
			flags_q.hotplug   <= 1'b0;
			offlined_q        <= '0;
		end else if (advance) begin
			cur_index_q     <= cur_index_nxt;
			applied_index_q <= applied_index_nxt;
			flags_q         <= flags_nxt;
			offlined_q      <= offlined_nxt;
		end
	end

	assign res.valid           = res_valid_s2;
	assign res.limit_update    = limit_update_s2;
	assign res.limit_index     = limit_index_s2;
	assign res.unlimited       = unlimited_s2;
	assign res.offline_request = offline_request_s2;
	assign res.online_request  = online_request_s2;
	assign res.core_number     = core_number_s2;
	assign res.offlined_cores  = offlined_cores_s2;

	// never both an offline and an online request in one result
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> !(offline_request_s2 && online_request_s2))
		else $error("offline and online request together");

	// core zero is never taken offline
	a_no_core0_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && offline_request_s2 |-> core_number_s2 != '0)
		else $error("offline request for core zero");

	// a failed read leaves the limit and the marked cores alone
	a_failed_read_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !reads_ok |=> applied_index_q == $past(applied_index_q) &&
			offlined_q == $past(offlined_q) && flags_q == $past(flags_q))
		else $error("state changed on a failed read");

	// an update flag always comes with a changed applied limit
	a_update_changes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && update_nxt |=> applied_index_q != $past(applied_index_q) ||
			flags_q.unlimited != $past(flags_q.unlimited))
		else $error("update flagged without a limit change");

	// a waiting s1 item is not dropped
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid_s1 && !advance |=> tick_valid_s1)
		else $error("pending tick lost");

endmodule

`default_nettype wire

// File: bench/throttle_checker.sv
// checker for the thermal throttle governor: predicts every result and compares it
`timescale 1ns / 1ps

module throttle_checker import tfct_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	tfct_cfg_if   cfg,
	tfct_tick_if  tick,
	tfct_res_if   res,
	output int    fail_count,
	output int    in_flight
);

	localparam int CORES = 4;
	localparam int PRINT_CAP = 200;

	typedef struct packed {
		logic       update;
		logic [5:0] index;
		logic       unlimited;
		logic       offline;
		logic       online;
		logic [1:0] core;
		logic [3:0] marked;
	} throttle_verdict_t;

	// register copies
	logic [7:0] lim_f, hyst_f, lim_c, hyst_c;
	logic [5:0] step, idx_lo, idx_hi;
	logic [3:0] mask;

	// governor state
	logic [5:0] cur_idx, app_idx;
	logic       app_unl, hp_pending;
	logic [3:0] marked_set;

	throttle_verdict_t pending_verdicts[$];
	throttle_verdict_t seen, want, fresh;
	int errors = 0;
	int queued = 0;

	assign fail_count = errors;
	assign in_flight  = queued;

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		if (errors < PRINT_CAP)
			$display("%0t mismatch %s: got %0d, predicted %0d", $realtime, what, got, exp_val);
		errors++;
	endtask

	task automatic govern_tick(input logic [7:0] ta, tb, tc, td, input logic [3:0] online,
			output throttle_verdict_t r);
		logic [7:0] t [4];
		int         f_floor, c_floor, nxt, c;
		bit         f_hot, f_cool, c_hot, c_cool, settled, found;
		logic [5:0] n_idx;
		logic       n_unl;
		logic [3:0] b;
		r = '0;
		t = '{ta, tb, tc, td};
		if (ta != 0 && tb != 0 && tc != 0 && td != 0) begin
			f_floor = (lim_f > hyst_f) ? int'(lim_f) - int'(hyst_f) : 0;
			c_floor = (lim_c > hyst_c) ? int'(lim_c) - int'(hyst_c) : 0;
			f_hot = 0;
			f_cool = 1;
			c_hot = 0;
			c_cool = 1;
			for (int i = 0; i < 4; i++) begin
				if (t[i] >= lim_f) f_hot = 1;
				if (int'(t[i]) >= f_floor) f_cool = 0;
				if (t[i] >= lim_c) c_hot = 1;
				if (int'(t[i]) > c_floor) c_cool = 0;
			end
			settled = 0;
			n_idx = app_idx;
			n_unl = app_unl;
			if (f_hot) begin
				if (cur_idx == idx_lo) begin
					hp_pending = 1;
					settled = 1;
				end else begin
					nxt = int'(cur_idx) - int'(step);
					if (nxt < int'(idx_lo)) nxt = int'(idx_lo);
					cur_idx = nxt[5:0];
					n_idx = cur_idx;
					n_unl = 0;
					hp_pending = 1;
				end
			end else if (f_cool) begin
				if (cur_idx == idx_hi) begin
					hp_pending = 0;
					settled = 1;
				end else begin
					nxt = int'(cur_idx) + int'(step);
					if (nxt >= int'(idx_hi)) begin
						cur_idx = idx_hi;
						n_unl = 1;
						hp_pending = 0;
					end else begin
						cur_idx = nxt[5:0];
						n_unl = 0;
						hp_pending = 1;
					end
					n_idx = cur_idx;
				end
			end
			if (!settled) begin
				if (n_idx == app_idx && n_unl == app_unl) begin
					hp_pending = 0;
				end else begin
					app_idx = n_idx;
					app_unl = n_unl;
					r.update = 1;
				end
			end
			found = 0;
			if (mask != 0 && (lim_f >= lim_c || hp_pending)) begin
				if (c_hot) begin
					// highest eligible core that is not already marked and down
					for (c = CORES - 1; c >= 1 && !found; c--) begin
						b = 4'b1 << c;
						if ((mask & b) != 0 && !((marked_set & b) != 0 && (online & b) == 0)) begin
							found = 1;
							r.offline = 1;
							r.core = c[1:0];
							marked_set |= b;
						end
					end
				end else if (marked_set != 0 && c_cool) begin
					// unmark upward until the first marked core that is down
					for (c = 0; c < CORES && !found; c++) begin
						b = 4'b1 << c;
						if ((marked_set & b) != 0) begin
							marked_set &= ~b;
							if ((online & b) == 0) begin
								found = 1;
								r.online = 1;
								r.core = c[1:0];
							end
						end
					end
				end
			end
		end
		r.index = app_idx;
		r.unlimited = app_unl;
		r.marked = marked_set;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_f = RST_FREQ_LIMIT_TEMP;
			hyst_f = RST_FREQ_HYSTERESIS;
			step = RST_INDEX_STEP[5:0];
			idx_lo = RST_LOW_INDEX[5:0];
			idx_hi = RST_HIGH_INDEX[5:0];
			lim_c = RST_CORE_LIMIT_TEMP;
			hyst_c = RST_CORE_HYSTERESIS;
			mask = RST_CORE_MASK[3:0];
			cur_idx = RST_HIGH_INDEX[5:0];
			app_idx = RST_HIGH_INDEX[5:0];
			app_unl = 1;
			hp_pending = 0;
			marked_set = '0;
			pending_verdicts.delete();
			queued = 0;
		end else begin
			if (res.valid && res.ready) begin
				seen.update = res.limit_update;
				seen.index = res.limit_index;
				seen.unlimited = res.unlimited;
				seen.offline = res.offline_request;
				seen.online = res.online_request;
				seen.core = res.core_number;
				seen.marked = res.offlined_cores;
				if (pending_verdicts.size() == 0) begin
					report_mismatch("unexpected result transaction", 1, 0);
				end else begin
					want = pending_verdicts.pop_front();
					if (seen.update !== want.update)
						report_mismatch("limit_update", seen.update, want.update);
					if (seen.index !== want.index)
						report_mismatch("limit_index", seen.index, want.index);
					if (seen.unlimited !== want.unlimited)
						report_mismatch("unlimited", seen.unlimited, want.unlimited);
					if (seen.offline !== want.offline)
						report_mismatch("offline_request", seen.offline, want.offline);
					if (seen.online !== want.online)
						report_mismatch("online_request", seen.online, want.online);
					if (seen.core !== want.core)
						report_mismatch("core_number", seen.core, want.core);
					if (seen.marked !== want.marked)
						report_mismatch("offlined_cores", seen.marked, want.marked);
				end
			end
			if (tick.valid && tick.ready) begin
				govern_tick(tick.temp_a, tick.temp_b, tick.temp_c, tick.temp_d,
					tick.online_cores, fresh);
				pending_verdicts.push_back(fresh);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_FREQ_LIMIT_TEMP: lim_f = cfg.data[7:0];
					REG_FREQ_HYSTERESIS: hyst_f = cfg.data[7:0];
					REG_INDEX_STEP:      step = cfg.data[5:0];
					REG_LOW_INDEX:       idx_lo = cfg.data[5:0];
					REG_HIGH_INDEX:      idx_hi = cfg.data[5:0];
					REG_CORE_LIMIT_TEMP: lim_c = cfg.data[7:0];
					REG_CORE_HYSTERESIS: hyst_c = cfg.data[7:0];
					REG_CORE_MASK:       mask = cfg.data[3:0];
					default: ;
				endcase
			end
			queued = pending_verdicts.size();
		end
	end

endmodule

// File: bench/testbench.sv
// top of the thermal throttle governor bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
	import tfct_pkg::*;

	logic clk;
	logic arst_n;

	tfct_cfg_if                                 cfg_ch ();
	tfct_tick_if #(.NUM_CORES(4))               tick_ch ();
	tfct_res_if  #(.NUM_CORES(4), .INDEX_BITS(6)) res_ch ();

	int fails;
	int in_flight;

	// settings in force, used to aim temperatures at the thresholds
	int fl_set, fh_set, cl_set, ch_set;
	int heat_target;
	logic [3:0] seen_offlined;

	// long receiver hold-offs asked by the stimulus and served by the receiver
	int holds_asked;
	int holds_done;

	thermal_freq_and_core_throttle #(
		.NUM_CORES (4),
		.INDEX_BITS(6)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.tick  (tick_ch),
		.res   (res_ch)
	);

	throttle_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_ch),
		.tick      (tick_ch),
		.res       (res_ch),
		.fail_count(fails),
		.in_flight (in_flight)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// last marked set seen, so online masks can follow what control asked for
	initial seen_offlined = '0;
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) seen_offlined <= res_ch.offlined_cores;
	end

	// receiver: switches between stall patterns, plus long hold-offs on request
	initial begin : receiver
		int stall_mode;
		int stall_left;
		int tick_cnt;
		stall_mode = 0;
		stall_left = 0;
		tick_cnt = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				// hold off long enough for the block to fill and stall its input
				res_ch.ready <= 1'b0;
				repeat (80) @(negedge clk);
				holds_done++;
			end else begin
				if (stall_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					stall_left = $urandom_range(20, 150);
				end
				stall_left--;
				tick_cnt++;
				case (stall_mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 3) != 0);
					2: res_ch.ready <= ($urandom_range(0, 9) < 3);
					default: res_ch.ready <= (tick_cnt % 5 != 0);
				endcase
			end
		end
	end

	// one poll tick transaction; returns at the falling edge after acceptance
	task automatic send_tick(input logic [7:0] a, b, c, d, input logic [3:0] online);
		tick_ch.valid <= 1'b1;
		tick_ch.temp_a <= a;
		tick_ch.temp_b <= b;
		tick_ch.temp_c <= c;
		tick_ch.temp_d <= d;
		tick_ch.online_cores <= online;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input tfct_reg_t r, input int unsigned v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// stop offering ticks and wait until every result is back
	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		@(negedge clk);
		while (in_flight != 0) @(negedge clk);
		// leave a margin after the last result
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_settings(input int fl, fh, st, lo, hi, cl, ch, mk);
		write_reg(REG_FREQ_LIMIT_TEMP, fl);
		write_reg(REG_FREQ_HYSTERESIS, fh);
		write_reg(REG_INDEX_STEP, st);
		write_reg(REG_LOW_INDEX, lo);
		write_reg(REG_HIGH_INDEX, hi);
		write_reg(REG_CORE_LIMIT_TEMP, cl);
		write_reg(REG_CORE_HYSTERESIS, ch);
		write_reg(REG_CORE_MASK, mk);
		cfg_ch.valid <= 1'b0;
		fl_set = fl;
		fh_set = fh;
		cl_set = cl;
		ch_set = ch;
	endtask

	function automatic logic [7:0] near_temp(input int center);
		int v;
		v = center + int'($urandom_range(0, 6)) - 3;
		if (v < 1) v = 1;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	// one random tick: mostly runs of similar temperatures aimed at a threshold,
	// some fully random readings and some failed reads
	task automatic random_tick();
		logic [7:0] t [4];
		logic [3:0] online;
		int r;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 5) == 0) begin
			case ($urandom_range(0, 5))
				0: heat_target = fl_set;
				1: heat_target = (fl_set > fh_set) ? fl_set - fh_set : 0;
				2: heat_target = cl_set;
				3: heat_target = (cl_set > ch_set) ? cl_set - ch_set : 0;
				4: heat_target = 255;
				default: heat_target = 1;
			endcase
		end
		for (int i = 0; i < 4; i++) begin
			if (r < 10) t[i] = 8'($urandom_range(0, 255));
			else t[i] = near_temp(heat_target);
		end
		// failed read on one sensor
		if (r >= 10 && r < 15) t[2'($urandom_range(0, 3))] = 8'd0;
		if ($urandom_range(0, 9) < 7) online = ~seen_offlined;
		else online = 4'($urandom_range(0, 15));
		send_tick(t[0], t[1], t[2], t[3], online);
	endtask

	// random ticks in bursts; optionally one long receiver hold-off midway
	task automatic random_items(input int count, input bit with_hold);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			if (with_hold && sent >= count / 2) begin
				with_hold = 0;
				holds_asked++;
				// keep offering while the receiver is held off
				repeat (16) random_tick();
				sent += 16;
			end
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < count; i++) begin
				random_tick();
				sent++;
			end
			// now and then let everything drain mid-phase
			if ($urandom_range(0, 19) == 0) begin
				wait_drained();
			end else if ($urandom_range(0, 2) != 0) begin
				gap = $urandom_range(1, 6);
				tick_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	initial begin : stimulus
		int fl, lo, cl;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_FREQ_LIMIT_TEMP;
		cfg_ch.data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.temp_a = '0;
		tick_ch.temp_b = '0;
		tick_ch.temp_c = '0;
		tick_ch.temp_d = '0;
		tick_ch.online_cores = '0;
		holds_asked = 0;
		holds_done = 0;
		fl_set = int'(RST_FREQ_LIMIT_TEMP);
		fh_set = int'(RST_FREQ_HYSTERESIS);
		cl_set = int'(RST_CORE_LIMIT_TEMP);
		ch_set = int'(RST_CORE_HYSTERESIS);
		heat_target = fl_set;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed pass on reset settings
		// failed read on each sensor in turn
		send_tick(8'd0, 8'd70, 8'd70, 8'd70, 4'hf);
		send_tick(8'd70, 8'd0, 8'd70, 8'd70, 4'hf);
		send_tick(8'd70, 8'd70, 8'd0, 8'd70, 4'hf);
		send_tick(8'd70, 8'd70, 8'd70, 8'd0, 4'hf);
		// hot everywhere: step down, offline the top core
		send_tick(8'd255, 8'd255, 8'd255, 8'd255, 4'hf);
		// exactly at the frequency limit, cool for cores: bring core back
		send_tick(8'd65, 8'd1, 8'd1, 8'd1, 4'h7);
		// exactly at the core limit
		send_tick(8'd1, 8'd1, 8'd1, 8'd75, 4'hf);
		// keep stepping down into the low clamp
		send_tick(8'd200, 8'd255, 8'd255, 8'd255, 4'h7);
		send_tick(8'd255, 8'd200, 8'd255, 8'd255, 4'h3);
		send_tick(8'd255, 8'd255, 8'd200, 8'd255, 4'h1);
		// hot while sitting at the low index
		send_tick(8'd200, 8'd200, 8'd200, 8'd200, 4'h0);
		// between the thresholds
		send_tick(8'd60, 8'd60, 8'd60, 8'd60, 4'h1);
		// just under limit minus hysteresis: step up and bring cores back
		send_tick(8'd59, 8'd59, 8'd59, 8'd59, 4'h1);
		send_tick(8'd1, 8'd1, 8'd1, 8'd1, 4'h3);
		send_tick(8'd1, 8'd1, 8'd1, 8'd1, 4'h7);
		send_tick(8'd1, 8'd1, 8'd1, 8'd1, 4'hf);
		send_tick(8'd1, 8'd1, 8'd1, 8'd1, 4'hf);
		// reaching the top index means unlimited
		send_tick(8'd1, 8'd1, 8'd1, 8'd1, 4'hf);
		// cool while already unlimited
		send_tick(8'd1, 8'd1, 8'd1, 8'd1, 4'hf);
		send_tick(8'd1, 8'd2, 8'd4, 8'd8, 4'ha);

		// wide-open extremes: core control every tick, every core in the mask
		wait_drained();
		apply_settings(255, 0, 63, 0, 63, 0, 255, 15);
		random_items(150, 0);

		// opposite extremes: everything hot, inverted index range, no core control
		wait_drained();
		apply_settings(0, 255, 0, 63, 1, 255, 0, 0);
		random_items(60, 0);

		// ordinary settings with core control always on, plus receiver hold-off
		wait_drained();
		apply_settings(70, 5, 1, 2, 20, 60, 8, 15);
		random_items(200, 1);

		// random settings
		for (int p = 0; p < 5; p++) begin
			wait_drained();
			fl = $urandom_range(30, 200);
			lo = $urandom_range(0, 30);
			cl = fl + int'($urandom_range(0, 40)) - 20;
			apply_settings(fl,
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 4),
				lo,
				($urandom_range(0, 4) == 0) ? $urandom_range(1, 63)
					: ((lo + 30 > 63) ? 63 : lo + int'($urandom_range(1, 30))),
				cl,
				$urandom_range(0, 25),
				$urandom_range(0, 15));
			random_items(200, p == 2);
		end

		// drain and give the verdict
		wait_drained();
		repeat (6) @(negedge clk);
		if (fails == 0 && in_flight == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
